// ===== hdl/stoc_pkg.sv =====
// shared types and constants of the seismic trace offset calculator
`timescale 1ns / 1ps

package stoc_pkg;

    localparam int COORD_W      = 16;
    localparam int STEP_W       = 16;
    localparam int COUNT_W      = 16;
    localparam int DATA_BYTES_W = 18;
    localparam int SLOT_W       = 19;
    localparam int INDEX_W      = 32;
    localparam int OFFSET_W     = 51;
    localparam int CFG_INDEX_W  = 3;
    localparam int CFG_DATA_W   = 32;
    localparam int DIV_STAGES   = 16;

    localparam logic [OFFSET_W-1:0] FILE_HEADER_BYTES  = 51'd3600;
    localparam logic [OFFSET_W-1:0] TRACE_HEADER_BYTES = 51'd240;
    localparam logic [OFFSET_W-1:0] DATA_BASE_BYTES    = FILE_HEADER_BYTES + TRACE_HEADER_BYTES;
    localparam logic [SLOT_W-1:0]   SLOT_HEADER_BYTES  = 19'd240;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_INLINE_BOUNDS     = 3'd0,
        REG_CROSSLINE_BOUNDS  = 3'd1,
        REG_PRIMARY_STEP      = 3'd2,
        REG_SECONDARY_STEP    = 3'd3,
        REG_INLINE_COUNT      = 3'd4,
        REG_CROSSLINE_COUNT   = 3'd5,
        REG_INLINE_IS_PRIMARY = 3'd6,
        REG_TRACE_DATA_BYTES  = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] il_min;
        logic signed [COORD_W-1:0] il_max;
        logic signed [COORD_W-1:0] xl_min;
        logic signed [COORD_W-1:0] xl_max;
        logic [STEP_W-1:0]         primary_step;
        logic [STEP_W-1:0]         secondary_step;
        logic [COUNT_W-1:0]        inline_count;
        logic [COUNT_W-1:0]        crossline_count;
        logic                      inline_is_primary;
        logic [DATA_BYTES_W-1:0]   trace_data_bytes;
        logic [INDEX_W-1:0]        grid_total;
    } cfg_t;

    typedef struct packed {
        logic               ok;
        logic [COORD_W-1:0] major_num;
        logic [COORD_W-1:0] minor_num;
    } front_t;

    typedef struct packed {
        logic [STEP_W-1:0]  rem;
        logic [COORD_W-1:0] acc;
    } lane_t;

    typedef struct packed {
        logic               ok;
        logic [COORD_W-1:0] major_q;
        logic [COORD_W-1:0] minor_q;
    } quot_t;

    typedef struct packed {
        logic                valid_res;
        logic [INDEX_W-1:0]  trace_index;
        logic [OFFSET_W-1:0] header_offset;
        logic [OFFSET_W-1:0] data_offset;
    } result_t;

endpackage

// ===== hdl/stoc_trace_if.sv =====
// input channel carrying one coordinate pair per word
`timescale 1ns / 1ps

interface stoc_trace_if import stoc_pkg::*;;
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] inline_number;
    logic signed [COORD_W-1:0] crossline_number;

    modport source (output valid, output inline_number, output crossline_number, input ready);
    modport sink (input valid, input inline_number, input crossline_number, output ready);
endinterface

// ===== hdl/stoc_result_if.sv =====
// output channel carrying one trace address result per word
`timescale 1ns / 1ps

interface stoc_result_if import stoc_pkg::*;;
    logic                valid;
    logic                ready;
    logic                valid_res;
    logic [INDEX_W-1:0]  trace_index;
    logic [OFFSET_W-1:0] header_offset;
    logic [OFFSET_W-1:0] data_offset;

    modport source (output valid, output valid_res, output trace_index, output header_offset,
                    output data_offset, input ready);
    modport sink (input valid, input valid_res, input trace_index, input header_offset,
                  input data_offset, output ready);
endinterface

// ===== hdl/stoc_cfg_if.sv =====
// configuration write channel, register index and write data
`timescale 1ns / 1ps

interface stoc_cfg_if import stoc_pkg::*;;
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hdl/stoc_cfg_regs.sv =====
// configuration register file and registered grid size
`timescale 1ns / 1ps

module stoc_cfg_regs import stoc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    stoc_cfg_if.sink   cfg_port,
    output cfg_t       cfg
);

    logic [CFG_DATA_W-1:0]   inline_bounds_reg;
    logic [CFG_DATA_W-1:0]   crossline_bounds_reg;
    logic [STEP_W-1:0]       primary_step_reg;
    logic [STEP_W-1:0]       secondary_step_reg;
    logic [COUNT_W-1:0]      inline_count_reg;
    logic [COUNT_W-1:0]      crossline_count_reg;
    logic                    inline_is_primary_reg;
    logic [DATA_BYTES_W-1:0] trace_data_bytes_reg;
    logic [INDEX_W-1:0]      grid_total_reg;
    logic [INDEX_W-1:0]      grid_total_next;

    assign cfg_port.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inline_bounds_reg     <= '0;
            crossline_bounds_reg  <= '0;
            primary_step_reg      <= 16'd1;
            secondary_step_reg    <= 16'd1;
            inline_count_reg      <= 16'd1;
            crossline_count_reg   <= 16'd1;
            inline_is_primary_reg <= 1'b1;
            trace_data_bytes_reg  <= 18'd4;
        end
        else if (cfg_port.valid)
        begin
            unique case (reg_idx_t'(cfg_port.index))
                REG_INLINE_BOUNDS:     inline_bounds_reg     <= cfg_port.data;
                REG_CROSSLINE_BOUNDS:  crossline_bounds_reg  <= cfg_port.data;
                REG_PRIMARY_STEP:      primary_step_reg      <= cfg_port.data[STEP_W-1:0];
                REG_SECONDARY_STEP:    secondary_step_reg    <= cfg_port.data[STEP_W-1:0];
                REG_INLINE_COUNT:      inline_count_reg      <= cfg_port.data[COUNT_W-1:0];
                REG_CROSSLINE_COUNT:   crossline_count_reg   <= cfg_port.data[COUNT_W-1:0];
                REG_INLINE_IS_PRIMARY: inline_is_primary_reg <= cfg_port.data[0];
                REG_TRACE_DATA_BYTES:  trace_data_bytes_reg  <= cfg_port.data[DATA_BYTES_W-1:0];
            endcase
        end
    end

    // grid size is registered, following the counts in the cycle after, long before any item needs it
    assign grid_total_next = {16'b0, inline_count_reg} * {16'b0, crossline_count_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_total_reg <= 32'd1;
        end
        else
        begin
            grid_total_reg <= grid_total_next;
        end
    end

    always_comb
    begin
        cfg.il_min            = $signed(inline_bounds_reg[15:0]);
        cfg.il_max            = $signed(inline_bounds_reg[31:16]);
        cfg.xl_min            = $signed(crossline_bounds_reg[15:0]);
        cfg.xl_max            = $signed(crossline_bounds_reg[31:16]);
        cfg.primary_step      = primary_step_reg;
        cfg.secondary_step    = secondary_step_reg;
        cfg.inline_count      = inline_count_reg;
        cfg.crossline_count   = crossline_count_reg;
        cfg.inline_is_primary = inline_is_primary_reg;
        cfg.trace_data_bytes  = trace_data_bytes_reg;
        cfg.grid_total        = grid_total_reg;
    end

endmodule

// ===== hdl/stoc_front.sv =====
// bounds check and axis selection stage
`timescale 1ns / 1ps

module stoc_front import stoc_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic                      in_valid,
    input  logic signed [COORD_W-1:0] inline_number,
    input  logic signed [COORD_W-1:0] crossline_number,
    input  cfg_t                      cfg,
    output logic                      out_valid,
    output front_t                    out_data
);

    logic               valid_reg;
    front_t             data_reg;
    front_t             data_next;
    logic               in_bounds;
    logic               step_ok;
    logic [COORD_W-1:0] il_off;
    logic [COORD_W-1:0] xl_off;

    always_comb
    begin
        in_bounds = ($signed(inline_number) >= $signed(cfg.il_min))
                 && ($signed(inline_number) <= $signed(cfg.il_max))
                 && ($signed(crossline_number) >= $signed(cfg.xl_min))
                 && ($signed(crossline_number) <= $signed(cfg.xl_max));
        step_ok   = (cfg.primary_step != '0) && (cfg.secondary_step != '0);
        // in bounds the distance is 0..65535, so 16 bits hold it exactly
        il_off    = inline_number - cfg.il_min;
        xl_off    = crossline_number - cfg.xl_min;
        data_next.ok        = in_bounds && step_ok;
        data_next.major_num = cfg.inline_is_primary ? il_off : xl_off;
        data_next.minor_num = cfg.inline_is_primary ? xl_off : il_off;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== hdl/stoc_divider.sv =====
// two-lane restoring divider, one quotient bit per stage
`timescale 1ns / 1ps

module stoc_divider import stoc_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   en,
    input  logic   in_valid,
    input  front_t in_data,
    input  cfg_t   cfg,
    output logic   out_valid,
    output quot_t  out_data
);

    logic  vld_reg  [DIV_STAGES];
    logic  vld_next [DIV_STAGES];
    logic  ok_reg   [DIV_STAGES];
    logic  ok_next  [DIV_STAGES];
    lane_t maj_reg  [DIV_STAGES];
    lane_t maj_next [DIV_STAGES];
    lane_t min_reg  [DIV_STAGES];
    lane_t min_next [DIV_STAGES];

    function automatic lane_t div_step(input lane_t cur, input logic [STEP_W-1:0] d);
        logic [STEP_W:0] sh;
        logic            ge;
        lane_t           r;
        sh     = {cur.rem, cur.acc[COORD_W-1]};
        ge     = (sh >= {1'b0, d});
        r.rem  = ge ? STEP_W'(sh - {1'b0, d}) : sh[STEP_W-1:0];
        r.acc  = {cur.acc[COORD_W-2:0], ge};
        return r;
    endfunction

    always_comb
    begin
        vld_next[0] = in_valid;
        ok_next[0]  = in_data.ok;
        maj_next[0] = div_step('{rem: '0, acc: in_data.major_num}, cfg.primary_step);
        min_next[0] = div_step('{rem: '0, acc: in_data.minor_num}, cfg.secondary_step);
        for (int k = 1; k < DIV_STAGES; k++)
        begin
            vld_next[k] = vld_reg[k-1];
            ok_next[k]  = ok_reg[k-1];
            maj_next[k] = div_step(maj_reg[k-1], cfg.primary_step);
            min_next[k] = div_step(min_reg[k-1], cfg.secondary_step);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < DIV_STAGES; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            for (int k = 0; k < DIV_STAGES; k++)
            begin
                vld_reg[k] <= vld_next[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < DIV_STAGES; k++)
            begin
                ok_reg[k]  <= ok_next[k];
                maj_reg[k] <= maj_next[k];
                min_reg[k] <= min_next[k];
            end
        end
    end

    assign out_valid        = vld_reg[DIV_STAGES-1];
    assign out_data.ok      = ok_reg[DIV_STAGES-1];
    assign out_data.major_q = maj_reg[DIV_STAGES-1].acc;
    assign out_data.minor_q = min_reg[DIV_STAGES-1].acc;

endmodule

// ===== hdl/stoc_back.sv =====
// index combine, grid check and byte offset stages
`timescale 1ns / 1ps

module stoc_back import stoc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    en,
    input  logic    in_valid,
    input  quot_t   in_data,
    input  cfg_t    cfg,
    output logic    out_valid,
    output result_t out_data
);

    // stage b1: major times row length
    logic                b1_valid_reg;
    logic                b1_ok_reg;
    logic [INDEX_W-1:0]  b1_prod_reg;
    logic [INDEX_W-1:0]  b1_prod_next;
    logic [COORD_W-1:0]  b1_minor_reg;
    logic [COUNT_W-1:0]  row_len;

    // stage b2: linear index and grid check
    logic                b2_valid_reg;
    logic                b2_ok_reg;
    logic                b2_ok_next;
    logic [INDEX_W-1:0]  b2_idx_reg;
    logic [INDEX_W:0]    b2_sum;
    logic [SLOT_W-1:0]   b2_slot_reg;
    logic [SLOT_W-1:0]   b2_slot_next;

    // stage b3: index times slot size
    logic                b3_valid_reg;
    logic                b3_ok_reg;
    logic [INDEX_W-1:0]  b3_idx_reg;
    logic [OFFSET_W-1:0] b3_mul_reg;
    logic [OFFSET_W-1:0] b3_mul_next;

    assign row_len      = cfg.inline_is_primary ? cfg.crossline_count : cfg.inline_count;
    assign b1_prod_next = {16'b0, in_data.major_q} * {16'b0, row_len};

    assign b2_sum       = {1'b0, b1_prod_reg} + {17'b0, b1_minor_reg};
    assign b2_ok_next   = b1_ok_reg && (b2_sum < {1'b0, cfg.grid_total});
    assign b2_slot_next = {1'b0, cfg.trace_data_bytes} + SLOT_HEADER_BYTES;

    assign b3_mul_next  = OFFSET_W'(b2_idx_reg) * OFFSET_W'(b2_slot_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg <= 1'b0;
            b2_valid_reg <= 1'b0;
            b3_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            b1_valid_reg <= in_valid;
            b2_valid_reg <= b1_valid_reg;
            b3_valid_reg <= b2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b1_ok_reg    <= in_data.ok;
            b1_prod_reg  <= b1_prod_next;
            b1_minor_reg <= in_data.minor_q;
            b2_ok_reg    <= b2_ok_next;
            b2_idx_reg   <= b2_sum[INDEX_W-1:0];
            b2_slot_reg  <= b2_slot_next;
            b3_ok_reg    <= b2_ok_reg;
            b3_idx_reg   <= b2_idx_reg;
            b3_mul_reg   <= b3_mul_next;
        end
    end

    // invalid traces report zero everywhere
    always_comb
    begin
        out_data.valid_res     = b3_ok_reg;
        out_data.trace_index   = b3_ok_reg ? b3_idx_reg : '0;
        out_data.header_offset = b3_ok_reg ? (b3_mul_reg + FILE_HEADER_BYTES) : '0;
        out_data.data_offset   = b3_ok_reg ? (b3_mul_reg + DATA_BASE_BYTES) : '0;
    end

    assign out_valid = b3_valid_reg;

endmodule

// ===== hdl/seismic_trace_offset_calc.sv =====
// top level: trace coordinate to linear index and file byte offsets
// path: front register, 16-stage divider and three back stages feed the output register
// throughput: one word per cycle while the skid word is free; the pipeline stages advance together
// the whole pipeline holds only while the output skid register is full
// reset: async active low, clears all valid bits and loads the register reset values
// configuration writes take effect at once; the grid size product follows in the cycle after
`timescale 1ns / 1ps

module seismic_trace_offset_calc import stoc_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    stoc_cfg_if.sink       cfg,
    stoc_trace_if.sink     trace_in,
    stoc_result_if.source  result_out
);

    cfg_t    cfg_q;
    logic    en;
    logic    front_valid;
    front_t  front_data;
    logic    div_valid;
    quot_t   div_data;
    logic    pipe_valid;
    result_t pipe_data;

    // output register plus skid word decouple the pipeline from result_out.ready
    logic    out_valid_reg;
    logic    out_valid_next;
    result_t out_data_reg;
    result_t out_data_next;
    logic    skid_valid_reg;
    logic    skid_valid_next;
    result_t skid_data_reg;
    result_t skid_data_next;
    logic    pop;
    logic    push;

    // pipeline moves whenever the skid word is free; a stalled result blocks input only once it fills
    assign en             = !skid_valid_reg;
    assign trace_in.ready = en;

    stoc_cfg_regs u_cfg_regs
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_port (cfg),
        .cfg      (cfg_q)
    );

    // bounds check and major/minor selection
    stoc_front u_front
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .en               (en),
        .in_valid         (trace_in.valid),
        .inline_number    (trace_in.inline_number),
        .crossline_number (trace_in.crossline_number),
        .cfg              (cfg_q),
        .out_valid        (front_valid),
        .out_data         (front_data)
    );

    // offset over step, both axes in parallel
    stoc_divider u_divider
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (front_valid),
        .in_data   (front_data),
        .cfg       (cfg_q),
        .out_valid (div_valid),
        .out_data  (div_data)
    );

    // index combine, grid check, slot multiply and offset add
    stoc_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (div_valid),
        .in_data   (div_data),
        .cfg       (cfg_q),
        .out_valid (pipe_valid),
        .out_data  (pipe_data)
    );

    assign pop  = out_valid_reg && result_out.ready;
    assign push = en && pipe_valid;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg)
        begin
            // pipeline is held, drain the skid word first
            if (pop)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg || pop)
            begin
                out_valid_next = 1'b1;
                out_data_next  = pipe_data;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_data_next  = pipe_data;
            end
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign result_out.valid         = out_valid_reg;
    assign result_out.valid_res     = out_data_reg.valid_res;
    assign result_out.trace_index   = out_data_reg.trace_index;
    assign result_out.header_offset = out_data_reg.header_offset;
    assign result_out.data_offset   = out_data_reg.data_offset;

endmodule

// ===== hdl/stoc_checker.sv =====
// port-level checker for the trace offset calculator and its bind
`timescale 1ns / 1ps

module stoc_checker import stoc_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                out_valid,
    input logic                out_ready,
    input logic                valid_res,
    input logic [INDEX_W-1:0]  trace_index,
    input logic [OFFSET_W-1:0] header_offset,
    input logic [OFFSET_W-1:0] data_offset
);

    // rejected trace carries zero index and offsets
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !valid_res) |-> (trace_index == '0 && header_offset == '0
                                       && data_offset == '0))
        else $error("invalid trace with nonzero fields");

    // sample data sits one trace header past the header
    a_data_after_header: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && valid_res) |-> (data_offset == OFFSET_W'(header_offset + TRACE_HEADER_BYTES)))
        else $error("data offset not header offset plus trace header");

    // every trace lies past the file header
    a_past_file_header: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && valid_res) |-> (header_offset >= FILE_HEADER_BYTES))
        else $error("header offset inside file header");

    // stalled result word holds
    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(valid_res) && $stable(trace_index)
                                       && $stable(header_offset) && $stable(data_offset)))
        else $error("result word changed while stalled");

endmodule

bind seismic_trace_offset_calc stoc_checker u_stoc_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (result_out.valid),
    .out_ready     (result_out.ready),
    .valid_res     (result_out.valid_res),
    .trace_index   (result_out.trace_index),
    .header_offset (result_out.header_offset),
    .data_offset   (result_out.data_offset)
);

// ===== verif/tb_seismic_trace_offset_calc.sv =====
// testbench for the seismic trace offset calculator: grid setups, coordinate streams, address checks
`timescale 1ns / 1ps

module tb_seismic_trace_offset_calc;
    import stoc_pkg::*;

    localparam int CLK_HALF       = 10;
    localparam int RESET_CYCLES   = 9;
    localparam int CYCLE_LIMIT    = 200000;
    localparam int RANDOM_PHASES  = 8;
    localparam int WORDS_PER_PHASE = 130;
    localparam int HOLD_CYCLES    = 300;
    localparam int TAIL_CYCLES    = 40;
    localparam int MAX_REPORTS    = 10;

    // ------------------------------------------------------------------
    // address predictor with its own copy of the grid registers
    // ------------------------------------------------------------------
    class trace_locator;
        result_t pending_addrs[$];
        logic signed [COORD_W-1:0] il_min, il_max, xl_min, xl_max;
        logic [STEP_W-1:0]         p_step, s_step;
        logic [COUNT_W-1:0]        il_cnt, xl_cnt;
        logic                      inline_major;
        logic [DATA_BYTES_W-1:0]   data_bytes;
        int unsigned n_checked;
        int unsigned n_in_grid;
        int unsigned n_errors;

        function new();
            il_min       = '0;
            il_max       = '0;
            xl_min       = '0;
            xl_max       = '0;
            p_step       = 16'd1;
            s_step       = 16'd1;
            il_cnt       = 16'd1;
            xl_cnt       = 16'd1;
            inline_major = 1'b1;
            data_bytes   = 18'd4;
            n_checked    = 0;
            n_in_grid    = 0;
            n_errors     = 0;
        endfunction

        function void set_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_INLINE_BOUNDS:
                begin
                    il_min = data[15:0];
                    il_max = data[31:16];
                end
                REG_CROSSLINE_BOUNDS:
                begin
                    xl_min = data[15:0];
                    xl_max = data[31:16];
                end
                REG_PRIMARY_STEP:      p_step       = data[STEP_W-1:0];
                REG_SECONDARY_STEP:    s_step       = data[STEP_W-1:0];
                REG_INLINE_COUNT:      il_cnt       = data[COUNT_W-1:0];
                REG_CROSSLINE_COUNT:   xl_cnt       = data[COUNT_W-1:0];
                REG_INLINE_IS_PRIMARY: inline_major = data[0];
                REG_TRACE_DATA_BYTES:  data_bytes   = data[DATA_BYTES_W-1:0];
                default: ;
            endcase
        endfunction

        function result_t locate_trace(logic signed [COORD_W-1:0] il,
                                       logic signed [COORD_W-1:0] xl);
            result_t     r;
            bit          ok;
            logic [31:0] il_off, xl_off;
            logic [63:0] major, minor, idx, slot, hdr;
            r  = '0;
            ok = 1'b1;
            idx = '0;
            if (il < il_min || il > il_max || xl < xl_min || xl > xl_max)
                ok = 1'b0;
            if (p_step == '0 || s_step == '0)
                ok = 1'b0;
            if (ok)
            begin
                il_off = 32'(int'(il) - int'(il_min));
                xl_off = 32'(int'(xl) - int'(xl_min));
                if (inline_major)
                begin
                    major = 64'(il_off / p_step);
                    minor = 64'(xl_off / s_step);
                    idx   = major * 64'(xl_cnt) + minor;
                end
                else
                begin
                    major = 64'(xl_off / p_step);
                    minor = 64'(il_off / s_step);
                    idx   = major * 64'(il_cnt) + minor;
                end
                if (idx >= 64'(il_cnt) * 64'(xl_cnt))
                    ok = 1'b0;
            end
            if (ok)
            begin
                slot            = 64'(TRACE_HEADER_BYTES) + 64'(data_bytes);
                hdr             = 64'(FILE_HEADER_BYTES) + idx * slot;
                r.valid_res     = 1'b1;
                r.trace_index   = idx[INDEX_W-1:0];
                r.header_offset = hdr[OFFSET_W-1:0];
                r.data_offset   = 51'(hdr + 64'(TRACE_HEADER_BYTES));
            end
            return r;
        endfunction

        function void note_trace(logic signed [COORD_W-1:0] il, logic signed [COORD_W-1:0] xl);
            pending_addrs.push_back(locate_trace(il, xl));
        endfunction

        function void check_word(result_t got);
            result_t want;
            if (pending_addrs.size() == 0)
            begin
                n_errors++;
                if (n_errors <= MAX_REPORTS)
                    $display("error: result word with nothing outstanding: valid=%0d idx=%0d",
                             got.valid_res, got.trace_index);
                return;
            end
            want = pending_addrs.pop_front();
            n_checked++;
            if (want.valid_res)
                n_in_grid++;
            if (got.valid_res !== want.valid_res || got.trace_index !== want.trace_index ||
                got.header_offset !== want.header_offset ||
                got.data_offset !== want.data_offset)
            begin
                n_errors++;
                if (n_errors <= MAX_REPORTS)
                    $display("error: word %0d expected v=%0d idx=%0d hdr=%0d dat=%0d, got v=%0d idx=%0d hdr=%0d dat=%0d",
                             n_checked, want.valid_res, want.trace_index, want.header_offset,
                             want.data_offset, got.valid_res, got.trace_index,
                             got.header_offset, got.data_offset);
            end
        endfunction

        function int pending();
            return pending_addrs.size();
        endfunction
    endclass

    // ------------------------------------------------------------------
    // clock, reset, channels, block
    // ------------------------------------------------------------------
    logic clk;
    logic rst_n;

    stoc_cfg_if    cfg_if ();
    stoc_trace_if  trace_if ();
    stoc_result_if res_if ();

    seismic_trace_offset_calc u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_if),
        .trace_in   (trace_if),
        .result_out (res_if)
    );

    always #CLK_HALF clk = ~clk;

    trace_locator locator;

    // shared among the stimulus, the result receiver, the monitors and the run-away guard
    bit          full_rate;
    int          hold_len;
    int unsigned cycle_count;
    int unsigned cfg_writes;
    int unsigned input_stalls;

    // current grid as the stimulus sees it, used only to aim coordinates
    int g_il_lo, g_il_hi, g_xl_lo, g_xl_hi;
    int g_il_pitch, g_xl_pitch, g_il_cells, g_xl_cells;

    // ------------------------------------------------------------------
    // monitors: every handshake is sampled at the rising edge, before
    // any of this edge's nonblocking updates land
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            // config copy follows the write channel exactly
            if (cfg_if.valid && cfg_if.ready)
            begin
                locator.set_reg(reg_idx_t'(cfg_if.index), cfg_if.data);
                cfg_writes++;
            end
            // each accepted coordinate word yields exactly one address word
            if (trace_if.valid && trace_if.ready)
                locator.note_trace(trace_if.inline_number, trace_if.crossline_number);
            if (trace_if.valid && !trace_if.ready)
                input_stalls++;
            if (res_if.valid && res_if.ready)
                locator.check_word('{valid_res:     res_if.valid_res,
                                     trace_index:   res_if.trace_index,
                                     header_offset: res_if.header_offset,
                                     data_offset:   res_if.data_offset});
        end
    end

    // run-away guard
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d words still outstanding",
                     cycle_count, locator.pending());
            $display("seismic_trace_offset_calc: mismatch");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // result receiver: random stalls per word, plus one long hold-off
    // on request so the pipeline backs up into the input
    // ------------------------------------------------------------------
    initial
    begin : result_receiver
        int stall;
        @(posedge rst_n);
        forever
        begin
            if (hold_len > 0)
            begin
                res_if.ready <= 1'b0;
                repeat (hold_len) @(posedge clk);
                hold_len = 0;
            end
            stall = full_rate ? 0 : $urandom_range(0, 8);
            if (stall > 0)
            begin
                res_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_if.ready <= 1'b1;
            do @(posedge clk); while (!res_if.valid);
        end
    end

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------

    // one register write, held until the channel takes it
    task automatic write_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] data);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= data;
        do @(posedge clk); while (!cfg_if.ready);
    endtask

    // full grid setup; narrow registers get junk in their unused upper bits
    task automatic load_grid(int il_lo, int il_hi, int xl_lo, int xl_hi, int p, int s,
                             int ic, int xc, int pri, int tdb);
        write_reg(REG_INLINE_BOUNDS,     {16'(il_hi), 16'(il_lo)});
        write_reg(REG_CROSSLINE_BOUNDS,  {16'(xl_hi), 16'(xl_lo)});
        write_reg(REG_PRIMARY_STEP,      {16'($urandom), 16'(p)});
        write_reg(REG_SECONDARY_STEP,    {16'($urandom), 16'(s)});
        write_reg(REG_INLINE_COUNT,      {16'($urandom), 16'(ic)});
        write_reg(REG_CROSSLINE_COUNT,   {16'($urandom), 16'(xc)});
        write_reg(REG_INLINE_IS_PRIMARY, {31'($urandom), 1'(pri)});
        write_reg(REG_TRACE_DATA_BYTES,  {14'($urandom), 18'(tdb)});
        cfg_if.valid <= 1'b0;
        g_il_lo    = il_lo;
        g_il_hi    = il_hi;
        g_xl_lo    = xl_lo;
        g_xl_hi    = xl_hi;
        g_il_pitch = pri ? p : s;
        g_xl_pitch = pri ? s : p;
        g_il_cells = ic;
        g_xl_cells = xc;
        // grid size product is registered behind the count registers, so wait for it to settle
        repeat (2) @(posedge clk);
    endtask

    // one coordinate word, random gap in front unless running at full rate
    task automatic send_trace(logic signed [COORD_W-1:0] il, logic signed [COORD_W-1:0] xl);
        int gap;
        gap = full_rate ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            trace_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        trace_if.valid            <= 1'b1;
        trace_if.inline_number    <= il;
        trace_if.crossline_number <= xl;
        do @(posedge clk); while (!trace_if.ready);
    endtask

    // wait until every address word has come back
    task automatic drain_results();
        trace_if.valid <= 1'b0;
        @(posedge clk);
        while (locator.pending() != 0)
            @(posedge clk);
    endtask

    // coordinate on one axis: mostly on the grid, some at the bounds, some anywhere
    function automatic logic signed [COORD_W-1:0] pick_coord(int lo, int hi, int pitch,
                                                             int cells);
        int     r;
        longint v;
        r = $urandom_range(0, 99);
        if (r < 70)
            v = longint'(lo) + longint'($urandom_range(0, cells)) * longint'(pitch) +
                longint'($urandom_range(0, pitch - 1));
        else if (r < 85)
        begin
            case ($urandom_range(0, 3))
                0:       v = lo;
                1:       v = hi;
                2:       v = longint'(lo) - 1;
                default: v = longint'(hi) + 1;
            endcase
        end
        else
            v = longint'($urandom_range(0, 65535)) - 32768;
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return 16'(v);
    endfunction

    // random grid; big selects near-maximal counts at unit steps
    task automatic random_grid(bit big);
        int     p, s, ic, xc, pri, tdb, ilp, xlp;
        longint il_span, xl_span, il_lo, xl_lo, il_hi, xl_hi, tmp;
        pri = $urandom_range(0, 1);
        p   = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 65535) : $urandom_range(1, 6);
        s   = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 65535) : $urandom_range(1, 6);
        if (big)
        begin
            p  = 1;
            s  = 1;
            ic = $urandom_range(30000, 65535);
            xc = $urandom_range(30000, 65535);
        end
        else
        begin
            ic = $urandom_range(1, 48);
            xc = $urandom_range(1, 48);
        end
        ilp     = pri ? p : s;
        xlp     = pri ? s : p;
        il_span = longint'(ic) * longint'(ilp);
        xl_span = longint'(xc) * longint'(xlp);
        if (il_span > 65536)
            il_span = 65536;
        if (xl_span > 65536)
            xl_span = 65536;
        il_lo = longint'($urandom_range(0, 32'(65536 - il_span))) - 32768;
        xl_lo = longint'($urandom_range(0, 32'(65536 - xl_span))) - 32768;
        il_hi = il_lo + il_span - 1 + longint'($urandom_range(0, ilp));
        xl_hi = xl_lo + xl_span - 1 + longint'($urandom_range(0, xlp));
        if (il_hi > 32767)
            il_hi = 32767;
        if (xl_hi > 32767)
            xl_hi = 32767;
        // now and then an inverted window on one axis
        if ($urandom_range(0, 15) == 0)
        begin
            tmp   = il_lo;
            il_lo = il_hi;
            il_hi = tmp;
        end
        case ($urandom_range(0, 3))
            0:       tdb = 0;
            1:       tdb = 262143;
            default: tdb = $urandom_range(0, 262143);
        endcase
        load_grid(int'(il_lo), int'(il_hi), int'(xl_lo), int'(xl_hi), p, s, ic, xc, pri, tdb);
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin : main_seq
        int ph;
        clk                       = 1'b0;
        rst_n                     = 1'b0;
        cfg_if.valid              = 1'b0;
        cfg_if.index              = '0;
        cfg_if.data               = '0;
        trace_if.valid            = 1'b0;
        trace_if.inline_number    = '0;
        trace_if.crossline_number = '0;
        res_if.ready              = 1'b0;
        full_rate                 = 1'b0;
        hold_len                  = 0;
        cycle_count               = 0;
        cfg_writes                = 0;
        input_stalls              = 0;
        locator                   = new();

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // registers at their reset values: single-trace grid at the origin
        send_trace(16'sd0, 16'sd0);
        send_trace(16'sd0, 16'sd1);
        send_trace(-16'sd32768, 16'sd32767);
        send_trace(16'sd32767, -16'sd32768);
        drain_results();

        // widest grid, unit steps, maximal counts and sample size
        load_grid(-32768, 32767, -32768, 32767, 1, 1, 65535, 65535, 1, 262143);
        send_trace(-16'sd32768, -16'sd32768);
        send_trace(16'sd32766, 16'sd32766);
        send_trace(16'sd32767, 16'sd32767);
        send_trace(16'sd32767, -16'sd32768);
        drain_results();

        // crossline-major order, maximal primary step, no sample bytes
        load_grid(-100, 100, -32768, 32767, 65535, 3, 67, 2, 0, 0);
        send_trace(16'sd100, 16'sd32767);
        send_trace(-16'sd100, -16'sd32768);
        send_trace(16'sd0, 16'sd0);
        drain_results();

        // inline minimum above maximum: nothing is in bounds
        load_grid(10, 5, 0, 0, 1, 1, 4, 4, 1, 100);
        send_trace(16'sd7, 16'sd0);
        send_trace(16'sd10, 16'sd0);
        drain_results();

        // zero primary step, then zero secondary step
        load_grid(-5, 5, -5, 5, 0, 1, 16, 16, 1, 8);
        send_trace(16'sd0, 16'sd0);
        drain_results();
        load_grid(-5, 5, -5, 5, 1, 0, 16, 16, 1, 8);
        send_trace(-16'sd5, -16'sd5);
        drain_results();

        // zero inline count, then zero crossline count
        load_grid(-5, 5, -5, 5, 1, 1, 0, 16, 1, 8);
        send_trace(16'sd0, 16'sd0);
        drain_results();
        load_grid(-5, 5, -5, 5, 1, 1, 16, 0, 0, 8);
        send_trace(16'sd0, 16'sd0);
        drain_results();

        // random phases, each on a fresh grid; two run back to back with no
        // idling, one of those under a long receiver hold-off, one near-maximal
        for (ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            full_rate = (ph == 2 || ph == 5);
            random_grid(ph == 6);
            if (ph == 5)
                hold_len = HOLD_CYCLES;
            repeat (WORDS_PER_PHASE)
                send_trace(pick_coord(g_il_lo, g_il_hi, g_il_pitch, g_il_cells),
                           pick_coord(g_xl_lo, g_xl_hi, g_xl_pitch, g_xl_cells));
            drain_results();
        end
        full_rate = 1'b0;

        // catch any stray word after the last expected one
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("checked %0d address words (%0d inside the grid) over %0d register writes",
                 locator.n_checked, locator.n_in_grid, cfg_writes);
        $display("input held off for %0d cycles, %0d errors", input_stalls, locator.n_errors);
        if (locator.n_errors == 0 && locator.pending() == 0)
            $display("seismic_trace_offset_calc: match");
        else
            $display("seismic_trace_offset_calc: mismatch");
        $finish;
    end

endmodule
